/* src/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int SPQ_CAPACITY = 16;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] item_value;
        logic signed [15:0] item_priority;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic               is_empty;
        logic signed [31:0] head_value;
        logic signed [15:0] head_priority;
        logic [4:0]         entry_count;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] ent_value;
        logic signed [15:0] ent_prio;
    } t_entry;

    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry item;
    } t_cell_ctrl;

endpackage

/* src/spq_cell.sv */
// One slot of the sorted chain: keeps, takes a new entry, or shifts from a neighbor.
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_valid,
    input  logic       i_left_lower,
    input  t_entry     i_left,
    input  t_entry     i_right,
    output t_entry     o_entry,
    output logic       o_lower
);

    t_entry r_entry;

    // A slot is "lower" when the new entry belongs at or ahead of it.
    assign o_lower = !i_valid || (r_entry.ent_prio < i_ctrl.item.ent_prio);
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.enq) begin
            if (o_lower) begin
                r_entry <= i_left_lower ? i_left : i_ctrl.item;
            end
        end else if (i_ctrl.deq) begin
            r_entry <= i_right;
        end
    end

endmodule

/* src/sorted_priority_queue_top.sv */
// Top level of the sorted priority queue built as a chain of compare-and-shift cells.
// Each accepted word gives one result, registered and shown in the cycle after it.
// Throughput: one word per cycle; every cell compares and shifts in parallel.
// busy is always low; the receiver cannot stall and results are never held.
// Reset empties the queue; slot contents are not cleared.
`timescale 1ns / 1ps

module sorted_priority_queue_top import spq_pkg::*; #(
    parameter int CAPACITY = SPQ_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_word,
    output logic      o_strobe,
    output t_out_word o_result
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_strobe;
    t_status       r_status;
    t_status       n_status;
    t_cell_ctrl    ctrl;
    t_entry        cell_entry [CAPACITY];
    logic          cell_lower [CAPACITY];
    logic          accept;
    logic          full;
    logic          empty;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (r_count == CW'(CAPACITY));
    assign empty  = (r_count == '0);

    always_comb begin
        ctrl.enq            = 1'b0;
        ctrl.deq            = 1'b0;
        ctrl.item.ent_value = i_word.item_value;
        ctrl.item.ent_prio  = i_word.item_priority;
        n_count             = r_count;
        n_status            = ST_DONE;
        if (accept) begin
            if (i_word.operation == OP_ENQUEUE) begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctrl.enq = 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end else begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    ctrl.deq = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry left_entry;
        t_entry right_entry;
        logic   left_lower;

        if (g == 0) begin : g_first
            assign left_entry = '0;
            assign left_lower = 1'b0;
        end else begin : g_mid
            assign left_entry = cell_entry[g-1];
            assign left_lower = cell_lower[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_inner
            assign right_entry = cell_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_valid      (CW'(g) < r_count),
            .i_left_lower (left_lower),
            .i_left       (left_entry),
            .i_right      (right_entry),
            .o_entry      (cell_entry[g]),
            .o_lower      (cell_lower[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_status <= ST_DONE;
        end else begin
            r_count  <= n_count;
            r_strobe <= accept;
            r_status <= n_status;
        end
    end

    assign o_strobe               = r_strobe;
    assign o_result.status        = r_status;
    assign o_result.is_empty      = empty;
    assign o_result.head_value    = empty ? '0 : cell_entry[0].ent_value;
    assign o_result.head_priority = empty ? '0 : cell_entry[0].ent_prio;
    assign o_result.entry_count   = 5'(r_count);

endmodule
